// ===== rtl/dkee_pkg.sv =====
// types and constants for the decimal keypad entry editor
// no dependencies; imported by decimal_keypad_entry_editor
package dkee_pkg;

  localparam int unsigned MANT_W  = 30;
  localparam int unsigned POINT_W = 5;
  localparam int unsigned COUNT_W = 4;
  localparam int unsigned SCALE_W = 32;
  localparam int unsigned CFG_W   = 4;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 72;

  // input modes
  localparam logic [1:0] MODE_APPLY       = 2'd0;
  localparam logic [1:0] MODE_CLEAR_APPLY = 2'd1;
  localparam logic [1:0] MODE_CLEAR       = 2'd2;
  localparam logic [1:0] MODE_HOLD        = 2'd3;

  // highest digit key code and the key codes above the digits
  localparam logic [3:0] KEY_MAX_DIGIT = 4'd9;
  localparam logic [3:0] KEY_DOT       = 4'd10;
  localparam logic [3:0] KEY_BACK      = 4'd11;

  // configuration register indexes
  localparam logic CFG_FRACTION_DIGITS = 1'b0;
  localparam logic CFG_OUTPUT_SCALE    = 1'b1;

  localparam logic [CFG_W-1:0] FRACTION_DIGITS_RST = 4'd2;
  localparam logic [CFG_W-1:0] OUTPUT_SCALE_RST    = 4'd3;

  // ceil(2^35 / 10), exact quotient for any 32-bit dividend
  localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
  localparam int unsigned DIV10_SHIFT = 35;

  localparam logic signed [POINT_W-1:0] NO_POINT = -5'sd1;

  typedef struct packed {
    logic [MANT_W-1:0]         mant;
    logic signed [POINT_W-1:0] point;
    logic [COUNT_W-1:0]        count;
  } entry_t;

  // ten to the power e, modulo 2^32
  function automatic logic [SCALE_W-1:0] pow10(input logic [3:0] e);
    logic [SCALE_W-1:0] p;
    unique case (e)
      4'd0:    p = 32'd1;
      4'd1:    p = 32'd10;
      4'd2:    p = 32'd100;
      4'd3:    p = 32'd1000;
      4'd4:    p = 32'd10000;
      4'd5:    p = 32'd100000;
      4'd6:    p = 32'd1000000;
      4'd7:    p = 32'd10000000;
      4'd8:    p = 32'd100000000;
      4'd9:    p = 32'd1000000000;
      4'd10:   p = 32'd1410065408;
      4'd11:   p = 32'd1215752192;
      4'd12:   p = 32'd3567587328;
      4'd13:   p = 32'd1316134912;
      4'd14:   p = 32'd276447232;
      default: p = 32'd2764472320;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/decimal_keypad_entry_editor.sv =====
// decimal keypad entry editor: builds a decimal number from keypad codes
// and reports it together with a power-of-ten rescaled value
// depends on dkee_pkg
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+--------------------------------------
//  in_     | in  | in_tvalid / in_tready  | in_tdata: mode, key_code
//  out_    | out | out_tvalid / out_tready| out_tdata: mantissa, point, count, scaled
//  cfg_    | in  | cfg_we                 | cfg_index, cfg_wdata
//
// one item per cycle sustained while out_tready stays high; a result passes
// through the entry register and then the output register before it is offered
// the entry updates in the accept cycle (digit append, or divide by ten through
// a reciprocal multiplier); the scale multiply feeds the output register
// rst_n (synchronous) clears the entry and loads the register defaults
// in_tready falls only when both stages are full and out_tready is low
module decimal_keypad_entry_editor #(
  parameter int unsigned MAX_DIGITS = 9
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [dkee_pkg::IN_TDATA_W-1:0]   in_tdata,  // [1:0] mode, [5:2] key_code
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [29:0] mantissa, [34:30] point_position, [38:35] char_count, [70:39] scaled_value
  output logic [dkee_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [dkee_pkg::CFG_W-1:0]        cfg_wdata
);
  import dkee_pkg::*;

  logic [CFG_W-1:0] frac_digits_r;
  logic [CFG_W-1:0] out_scale_r;

  entry_t ent_r, ent_nxt;
  entry_t base;

  logic             s1_valid_r;
  entry_t           s1_ent_r;
  logic [3:0]       s1_exp_r;
  logic [3:0]       exp_nxt;

  logic             s2_valid_r;
  entry_t           s2_ent_r;
  logic [SCALE_W-1:0] s2_scaled_r;

  logic s2_load, s1_load;
  logic [1:0] mode;
  logic [3:0] key;
  logic       clear;
  logic       apply;

  logic [MANT_W+31:0] div_prod;
  logic [MANT_W-1:0]  mant_div10;
  logic [MANT_W+3:0]  mant_append;
  logic               digit_ok;
  logic [3:0]         pt_mag;
  logic [MANT_W+SCALE_W-1:0] scale_prod;

  assign mode = in_tdata[1:0];
  assign key  = in_tdata[5:2];

  // handshake chain
  assign s2_load   = s1_valid_r && (!s2_valid_r || out_tready);
  assign s1_load   = in_tvalid && in_tready;
  assign in_tready = !s1_valid_r || s2_load;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frac_digits_r <= FRACTION_DIGITS_RST;
      out_scale_r   <= OUTPUT_SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRACTION_DIGITS: frac_digits_r <= cfg_wdata;
        CFG_OUTPUT_SCALE:    out_scale_r   <= cfg_wdata;
        default:             ;
      endcase
    end
  end

  // entry update
  always_comb begin
    clear = (mode == MODE_CLEAR_APPLY) || (mode == MODE_CLEAR);
    apply = (mode == MODE_APPLY) || (mode == MODE_CLEAR_APPLY);
    if (clear) begin
      base.mant  = '0;
      base.point = NO_POINT;
      base.count = '0;
    end else begin
      base = ent_r;
    end
  end

  assign div_prod    = base.mant * DIV10_RECIP;
  assign mant_div10  = MANT_W'(div_prod[MANT_W+31:DIV10_SHIFT]);
  assign mant_append = ({4'd0, base.mant} << 3) + ({4'd0, base.mant} << 1)
                     + {{MANT_W{1'b0}}, key};

  // leading zeros dropped, fraction and total digit limits honored
  assign digit_ok = ((key != 4'd0) || (base.mant != '0) || !base.point[POINT_W-1])
                 && ($signed(base.point) < $signed({1'b0, frac_digits_r}))
                 && (base.count < COUNT_W'(MAX_DIGITS));

  always_comb begin
    ent_nxt = base;
    if (apply) begin
      if (key <= KEY_MAX_DIGIT) begin
        if (digit_ok) begin
          ent_nxt.mant  = mant_append[MANT_W-1:0];
          ent_nxt.count = base.count + 4'd1;
          if (!base.point[POINT_W-1]) ent_nxt.point = base.point + 5'sd1;
        end
      end else if (key == KEY_DOT) begin
        if (base.point[POINT_W-1]) begin
          ent_nxt.point = '0;
          if ((base.mant == '0) && (base.count != 4'd15)) ent_nxt.count = base.count + 4'd1;
        end
      end else if (key == KEY_BACK) begin
        if (base.point == '0) begin
          ent_nxt.point = NO_POINT;
          if (base.mant == '0) ent_nxt.count = '0;
        end else begin
          ent_nxt.mant = mant_div10;
          if (base.count != '0) begin
            ent_nxt.count = base.count - 4'd1;
            if (!base.point[POINT_W-1]) ent_nxt.point = base.point - 5'sd1;
          end
        end
      end
    end
  end

  // scale exponent: point positions above zero lower it, floored at zero
  always_comb begin
    pt_mag  = ent_nxt.point[3:0];
    exp_nxt = out_scale_r;
    if (!ent_nxt.point[POINT_W-1] && (ent_nxt.point != '0)) begin
      exp_nxt = (out_scale_r >= pt_mag) ? (out_scale_r - pt_mag) : 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.mant  <= '0;
      ent_r.point <= NO_POINT;
      ent_r.count <= '0;
      s1_valid_r  <= 1'b0;
    end else begin
      if (s1_load) begin
        ent_r      <= ent_nxt;
        s1_valid_r <= 1'b1;
      end else if (s2_load) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_ent_r <= ent_nxt;
      s1_exp_r <= exp_nxt;
    end
  end

  // scale multiply into the output register
  assign scale_prod = s1_ent_r.mant * pow10(s1_exp_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_load) begin
      s2_valid_r <= 1'b1;
    end else if (out_tready) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_ent_r    <= s1_ent_r;
      s2_scaled_r <= scale_prod[SCALE_W-1:0];
    end
  end

  assign out_tvalid = s2_valid_r;
  assign out_tdata  = {1'b0, s2_scaled_r, s2_ent_r.count, s2_ent_r.point, s2_ent_r.mant};

endmodule
